// ===== rtl/npm_pkg.sv =====
// Shared types, sizes and codes for the nearest point matcher.
// Used by every module of the block; no dependencies.
package npm_pkg;

	localparam int POOL_SLOTS  = 16;
	localparam int QUEUE_SLOTS = 16;
	localparam int COORD_BITS  = 16;

	localparam int ID_W     = 16;
	localparam int POS_W    = 16;
	localparam int ACT_W    = 2;
	localparam int STAT_W   = 3;
	localparam int DIST_W   = 33;
	localparam int SQ_W     = 2 * COORD_BITS;
	localparam int DFULL_W  = SQ_W + 1;

	localparam int IDX_W    = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int CNT_W    = $clog2(POOL_SLOTS + 1);
	localparam int QIDX_W   = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
	localparam int QCNT_W   = $clog2(QUEUE_SLOTS + 1);

	localparam logic [ACT_W-1:0] ACT_POOL  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REQ   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_MATCH = 2'd2;

	localparam logic [STAT_W-1:0] ST_ADDED = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 3'd1;
	localparam logic [STAT_W-1:0] ST_MATCH = 3'd2;
	localparam logic [STAT_W-1:0] ST_NODRV = 3'd3;
	localparam logic [STAT_W-1:0] ST_EMPTY = 3'd4;

	typedef struct packed {
		logic [ID_W-1:0]              id;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} point_t;

	typedef struct packed {
		logic             add;
		logic             remove;
		logic [IDX_W-1:0] rm_idx;
	} pool_ctl_t;

	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

endpackage

// ===== rtl/npm_pool.sv =====
// Ordered point pool: append at the end, remove one entry with compaction.
// Depends on npm_pkg.
module npm_pool (
	input  logic                       clk,
	input  logic                       arst_n,
	input  npm_pkg::pool_ctl_t         ctl,
	input  npm_pkg::point_t            wr_pt,
	input  logic [npm_pkg::IDX_W-1:0]  rd_idx,
	output npm_pkg::point_t            rd_pt,
	output logic [npm_pkg::CNT_W-1:0]  count,
	output logic                       full
);
	import npm_pkg::*;

	point_t           ent_q [POOL_SLOTS];
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(POOL_SLOTS));
	assign count = cnt_q;
	assign rd_pt = ent_q[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.add && !full) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (ctl.remove) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.add && !full) begin
			ent_q[cnt_q[IDX_W-1:0]] <= wr_pt;
		end else if (ctl.remove) begin
			for (int i = 0; i < POOL_SLOTS - 1; i++) begin
				if (CNT_W'(i) >= CNT_W'(ctl.rm_idx) && CNT_W'(i) + CNT_W'(1) < cnt_q) begin
					ent_q[i] <= ent_q[i+1];
				end
			end
		end
	end

endmodule

// ===== rtl/npm_queue.sv =====
// Circular request queue with head pointer and fill count.
// Depends on npm_pkg.
module npm_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  npm_pkg::queue_ctl_t        ctl,
	input  npm_pkg::point_t            wr_pt,
	output npm_pkg::point_t            head_pt,
	output logic [npm_pkg::QCNT_W-1:0] count,
	output logic                       full
);
	import npm_pkg::*;

	localparam int SUM_W = QCNT_W + 1;

	point_t            ent_q [QUEUE_SLOTS];
	logic [QIDX_W-1:0] head_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]  tail;

	assign full    = (cnt_q == QCNT_W'(QUEUE_SLOTS));
	assign count   = cnt_q;
	assign head_pt = ent_q[head_q];
	assign sum     = SUM_W'(head_q) + SUM_W'(cnt_q);
	assign tail    = (sum >= SUM_W'(QUEUE_SLOTS)) ? sum - SUM_W'(QUEUE_SLOTS) : sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else if (ctl.push && !full) begin
			cnt_q <= cnt_q + QCNT_W'(1);
		end else if (ctl.pop) begin
			cnt_q  <= cnt_q - QCNT_W'(1);
			head_q <= (head_q == QIDX_W'(QUEUE_SLOTS - 1)) ? '0 : head_q + QIDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push && !full) begin
			ent_q[tail[QIDX_W-1:0]] <= wr_pt;
		end
	end

endmodule

// ===== rtl/npm_sqdist.sv =====
// Shared difference-square unit: one registered square per cycle, with a
// holding register so two squares sum into a distance. Depends on npm_pkg.
module npm_sqdist (
	input  logic                               clk,
	input  logic signed [npm_pkg::COORD_BITS-1:0] a,
	input  logic signed [npm_pkg::COORD_BITS-1:0] b,
	input  logic                               hold,
	output logic [npm_pkg::DFULL_W-1:0]        sum_sq
);
	import npm_pkg::*;

	logic signed [COORD_BITS:0] diff;
	logic [COORD_BITS-1:0]      mag;
	logic [SQ_W-1:0]            prod_q;
	logic [SQ_W-1:0]            first_q;

	assign diff   = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
	assign mag    = diff[COORD_BITS] ? COORD_BITS'(-diff) : COORD_BITS'(diff);
	assign sum_sq = DFULL_W'(first_q) + DFULL_W'(prod_q);

	always_ff @(posedge clk) begin
		prod_q <= SQ_W'(mag) * SQ_W'(mag);
		if (hold) begin
			first_q <= prod_q;
		end
	end

endmodule

// ===== rtl/nearest_point_matcher.sv =====
// Nearest point matcher: top level with the request sequencer and output register.
// Depends on npm_pkg, npm_pool, npm_queue and npm_sqdist.
//
// Usage: the input channel (in_valid/in_stall) carries one request with
// action, ident, pos_x and pos_y. Action 0 appends a point to the pool,
// action 1 queues a rider request; each answers with one result (added or
// full) that has last set. Action 2 drains the queue: one result per queued
// request (matched, or no driver when the pool is empty), last set on the
// final one; with an empty queue it answers a single queue-empty result.
// Action 3 is ignored and gives no result.
// Timing: the input is taken only while the sequencer is idle. An add is
// accepted, then the output register is loaded. A match, after the accept,
// for each queued request pops the queue (LOAD), scans every pool point
// through the DX, DY and CMP steps, and then emits its result (EMIT).
// The single shared squarer, used for dx and then dy of every point, sets
// the separate DX and DY steps per point.
// The output channel (out_valid/out_stall) comes from a register; while the
// receiver stalls, the held result stays and the sequencer waits in its emit
// step. Reset empties pool and queue and drops any pending result.
module nearest_point_matcher (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [npm_pkg::ACT_W-1:0]          action,
	input  logic [npm_pkg::ID_W-1:0]           ident,
	input  logic signed [npm_pkg::POS_W-1:0]   pos_x,
	input  logic signed [npm_pkg::POS_W-1:0]   pos_y,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [npm_pkg::STAT_W-1:0]         status,
	output logic [npm_pkg::ID_W-1:0]           rider_id,
	output logic [npm_pkg::ID_W-1:0]           driver_id,
	output logic [npm_pkg::DIST_W-1:0]         dist_sq,
	output logic                               last
);
	import npm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_DX,
		S_DY,
		S_CMP,
		S_EMIT
	} state_t;

	state_t                       state_q;
	logic                         in_acc;
	logic                         out_free;
	point_t                       in_pt;
	point_t                       pool_rd;
	point_t                       q_head;
	pool_ctl_t                    pool_ctl;
	queue_ctl_t                   q_ctl;
	logic [CNT_W-1:0]             pool_cnt;
	logic                         pool_full;
	logic [QCNT_W-1:0]            q_cnt;
	logic                         q_full;
	logic signed [COORD_BITS-1:0] op_a;
	logic signed [COORD_BITS-1:0] op_b;
	logic [DFULL_W-1:0]           cand_dsq;
	logic                         scan_end;

	logic [IDX_W-1:0]             idx_q;
	logic [IDX_W-1:0]             best_idx_q;
	logic [ID_W-1:0]              best_id_q;
	logic [DFULL_W-1:0]           best_dist_q;
	logic [ID_W-1:0]              rid_q;
	logic signed [COORD_BITS-1:0] rx_q;
	logic signed [COORD_BITS-1:0] ry_q;
	logic [STAT_W-1:0]            st_q;
	logic                         fin_q;
	logic                         rm_q;

	logic                         out_valid_q;
	logic [STAT_W-1:0]            status_q;
	logic [ID_W-1:0]              rider_id_q;
	logic [ID_W-1:0]              driver_id_q;
	logic [DIST_W-1:0]            dist_sq_q;
	logic                         last_q;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign in_pt.id = ident;
	assign in_pt.x  = COORD_BITS'($unsigned(pos_x));
	assign in_pt.y  = COORD_BITS'($unsigned(pos_y));

	assign pool_ctl.add    = in_acc && (action == ACT_POOL);
	assign pool_ctl.remove = (state_q == S_EMIT) && out_free && rm_q;
	assign pool_ctl.rm_idx = best_idx_q;
	assign q_ctl.push      = in_acc && (action == ACT_REQ);
	assign q_ctl.pop       = (state_q == S_LOAD);

	assign op_a     = (state_q == S_DX) ? rx_q : ry_q;
	assign op_b     = (state_q == S_DX) ? pool_rd.x : pool_rd.y;
	assign scan_end = (CNT_W'(idx_q) + CNT_W'(1) == pool_cnt);

	npm_pool u_pool (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pool_ctl),
		.wr_pt  (in_pt),
		.rd_idx (idx_q),
		.rd_pt  (pool_rd),
		.count  (pool_cnt),
		.full   (pool_full)
	);

	npm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (q_ctl),
		.wr_pt   (in_pt),
		.head_pt (q_head),
		.count   (q_cnt),
		.full    (q_full)
	);

	npm_sqdist u_sqdist (
		.clk    (clk),
		.a      (op_a),
		.b      (op_b),
		.hold   (state_q == S_DY),
		.sum_sq (cand_dsq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			best_idx_q  <= '0;
			best_id_q   <= '0;
			best_dist_q <= '0;
			rid_q       <= '0;
			rx_q        <= '0;
			ry_q        <= '0;
			st_q        <= ST_ADDED;
			fin_q       <= 1'b0;
			rm_q        <= 1'b0;
			status_q    <= ST_ADDED;
			rider_id_q  <= '0;
			driver_id_q <= '0;
			dist_sq_q   <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						rid_q       <= '0;
						best_id_q   <= '0;
						best_dist_q <= '0;
						fin_q       <= 1'b1;
						rm_q        <= 1'b0;
						unique case (action)
							ACT_POOL: begin
								st_q    <= pool_full ? ST_FULL : ST_ADDED;
								state_q <= S_EMIT;
							end
							ACT_REQ: begin
								st_q    <= q_full ? ST_FULL : ST_ADDED;
								state_q <= S_EMIT;
							end
							ACT_MATCH: begin
								st_q    <= ST_EMPTY;
								state_q <= (q_cnt == '0) ? S_EMIT : S_LOAD;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_LOAD: begin
					rid_q       <= q_head.id;
					rx_q        <= q_head.x;
					ry_q        <= q_head.y;
					fin_q       <= (q_cnt == QCNT_W'(1));
					idx_q       <= '0;
					best_id_q   <= '0;
					best_dist_q <= '0;
					rm_q        <= 1'b0;
					if (pool_cnt == '0) begin
						st_q    <= ST_NODRV;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_DX;
					end
				end
				S_DX: begin
					state_q <= S_DY;
				end
				S_DY: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (idx_q == '0 || cand_dsq < best_dist_q) begin
						best_dist_q <= cand_dsq;
						best_id_q   <= pool_rd.id;
						best_idx_q  <= idx_q;
					end
					if (scan_end) begin
						st_q    <= ST_MATCH;
						rm_q    <= 1'b1;
						state_q <= S_EMIT;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= S_DX;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= st_q;
						rider_id_q  <= rid_q;
						driver_id_q <= best_id_q;
						dist_sq_q   <= DIST_W'(best_dist_q);
						last_q      <= fin_q;
						state_q     <= fin_q ? S_IDLE : S_LOAD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign rider_id  = rider_id_q;
	assign driver_id = driver_id_q;
	assign dist_sq   = dist_sq_q;
	assign last      = last_q;

endmodule

// ===== rtl/npm_checker.sv =====
// Port-level checks for the nearest point matcher, bound to the top level.
// Depends on npm_pkg and nearest_point_matcher.
module npm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic [npm_pkg::ACT_W-1:0]        action,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [npm_pkg::STAT_W-1:0]       status,
	input logic [npm_pkg::ID_W-1:0]         rider_id,
	input logic [npm_pkg::ID_W-1:0]         driver_id,
	input logic [npm_pkg::DIST_W-1:0]       dist_sq,
	input logic                             last
);
	import npm_pkg::*;

	logic in_acc;

	assign in_acc = in_valid && !in_stall;

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(rider_id)
			&& $stable(driver_id) && $stable(dist_sq) && $stable(last))
		else $error("stalled result changed");

	// An accepted add or rider request keeps the block busy until its result is out.
	a_add_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (action == ACT_POOL || action == ACT_REQ) |=> in_stall)
		else $error("block idle right after an add");

	// An unused action is dropped without leaving idle.
	a_unused_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && action != ACT_POOL && action != ACT_REQ && action != ACT_MATCH
			|=> !in_stall)
		else $error("unused action left the block busy");

	// More results are due while a result without last is shown.
	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("block idle with results still due");

	// Results that are not last only come from a match.
	a_mid_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == ST_MATCH || status == ST_NODRV)
		else $error("add or empty result without last");

endmodule

bind nearest_point_matcher npm_checker u_npm_checker (.*);
